// ----- hdl/ttlc_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package ttlc_pkg;
    localparam int ENTRIES_DEF     = 128;
    localparam int HANDLE_BITS_DEF = 16;
    localparam int KEY_BITS        = 256;
    localparam int TIME_BITS       = 40;
    localparam int EXP_BITS        = 41;
    localparam int STAMP_BITS      = 64;
    localparam int TTL_BITS        = 32;
    localparam int HANDLE_W        = 16;
    localparam logic [TTL_BITS-1:0] TTL_RESET = 32'd3600;
    localparam logic CMD_LOOKUP = 1'b0;
    localparam logic CMD_STORE  = 1'b1;

    // Compare-unit request from the sequencer
    typedef struct packed {
        logic                  check_valid;
        logic                  check_key;
        logic                  check_expired;
        logic                  check_oldest;
    } cmp_ctl_t;
endpackage
`default_nettype wire

// ----- hdl/ttlc_cmp.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Shared compare unit: one slot against the request and the best candidate.
module ttlc_cmp (
    input  wire ttlc_pkg::cmp_ctl_t                   ctl,
    input  wire                                       slot_vld,
    input  wire [ttlc_pkg::KEY_BITS-1:0]              slot_key,
    input  wire [ttlc_pkg::EXP_BITS-1:0]              slot_exp,
    input  wire [ttlc_pkg::STAMP_BITS-1:0]            slot_stamp,
    input  wire [ttlc_pkg::KEY_BITS-1:0]              req_key,
    input  wire [ttlc_pkg::TIME_BITS-1:0]             now,
    input  wire                                       best_vld,
    input  wire [ttlc_pkg::EXP_BITS-1:0]              best_exp,
    input  wire [ttlc_pkg::STAMP_BITS-1:0]            best_stamp,
    output logic                                      take
);
    logic expired, newer, better;
    always_comb begin
        expired = (slot_exp != '0) && (slot_exp <= {1'b0, now});
        newer   = slot_stamp > best_stamp;
        better  = !best_vld || (slot_exp < best_exp) || ((slot_exp == best_exp) && newer);
        take    = slot_vld;
        if (ctl.check_key)     take = take && (slot_key == req_key);
        if (ctl.check_expired) take = take && expired && (!best_vld || newer);
        if (ctl.check_oldest)  take = take && better;
        if (!ctl.check_valid)  take = !slot_vld;
    end
endmodule
`default_nettype wire

// ----- hdl/ttl_keyed_cache_with_expiry_eviction.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Keyed TTL cache with earliest-expiry eviction.
// Input channel s_axis carries one request per transaction: the command
// (lookup or store) on tuser, and a 256-bit key with handle and timing
// fields on tdata. Each request gives exactly one result transaction on m_axis.
// A sequencer walks the slots one per cycle through one shared compare unit
// and a slot memory with one read per cycle and a separate write (registered data).
// Every request makes a key scan over all slots. A store of a new key into a
// full cache adds an expired-entry scan and, if none is found, an
// earliest-expiry scan; a new entry then needs a free-slot scan.
// A request passes through the accepting idle state, its scans, a write
// state on stores and the output state.
// s_axis_tready is high only while the block is idle, and the result sits
// in an output register; a stalled receiver holds the block until taken.
// Reset clears the valid bits, entry count, insert counter and sets the
// TTL register to 3600. cfg_we writes the TTL register.
module ttl_keyed_cache_with_expiry_eviction #(
    parameter int ENTRIES     = ttlc_pkg::ENTRIES_DEF,
    parameter int HANDLE_BITS = ttlc_pkg::HANDLE_BITS_DEF
) (
    input  wire          aclk,
    input  wire          aresetn,
    input  wire          cfg_we,
    input  wire [31:0]   cfg_wdata,
    input  wire          s_axis_tvalid,
    output logic         s_axis_tready,
    // cmd
    input  wire          s_axis_tuser,
    // key_word_0..3, now_seconds, item_handle, next_upd
    input  wire [351:0]  s_axis_tdata,
    output logic         m_axis_tvalid,
    input  wire          m_axis_tready,
    // hit, found_handle, replaced, evicted, freed_handle, stored_expiry, pad 4
    output logic [79:0]  m_axis_tdata
);
    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW = $clog2(ENTRIES + 1);
    localparam logic [CW-1:0] FULL = CW'(ENTRIES);
    localparam logic [IW:0]   LAST = (IW + 1)'(ENTRIES - 1);

    typedef enum logic [2:0] {
        S_IDLE, S_KEY, S_EXP, S_OLD, S_FREE, S_WRITE, S_OUT
    } state_t;

    // slot memory
    logic [ttlc_pkg::KEY_BITS-1:0]   mem_key   [ENTRIES];
    logic [HANDLE_BITS-1:0]          mem_hdl   [ENTRIES];
    logic [ttlc_pkg::EXP_BITS-1:0]   mem_exp   [ENTRIES];
    logic [ttlc_pkg::STAMP_BITS-1:0] mem_stamp [ENTRIES];
    logic [ENTRIES-1:0]              valid_reg;

    logic [ttlc_pkg::KEY_BITS-1:0]   rd_key_reg;
    logic [HANDLE_BITS-1:0]          rd_hdl_reg;
    logic [ttlc_pkg::EXP_BITS-1:0]   rd_exp_reg;
    logic [ttlc_pkg::STAMP_BITS-1:0] rd_stamp_reg;
    logic                            rd_vld_reg;
    logic                            rd_live_reg;
    logic [IW-1:0]                   rd_idx_reg;

    state_t                          state_reg;
    logic [IW:0]                     addr_reg;
    logic [ttlc_pkg::TTL_BITS-1:0]   ttl_reg;
    logic [CW-1:0]                   count_reg;
    logic [ttlc_pkg::STAMP_BITS-1:0] ctr_reg;

    logic                            cmd_reg;
    logic [ttlc_pkg::KEY_BITS-1:0]   key_reg;
    logic [ttlc_pkg::TIME_BITS-1:0]  now_reg;
    logic [HANDLE_BITS-1:0]          hdl_reg;
    logic [ttlc_pkg::EXP_BITS-1:0]   sexp_reg;

    logic                            best_vld_reg;
    logic [IW-1:0]                   best_idx_reg;
    logic [ttlc_pkg::EXP_BITS-1:0]   best_exp_reg;
    logic [ttlc_pkg::STAMP_BITS-1:0] best_stamp_reg;
    logic [HANDLE_BITS-1:0]          best_hdl_reg;

    logic                            hit_reg, repl_reg, evic_reg;
    logic [ttlc_pkg::HANDLE_W-1:0]   found_reg, freed_reg;

    ttlc_pkg::cmp_ctl_t              ctl;
    logic                            take;
    logic [ttlc_pkg::EXP_BITS-1:0]   e_sum;
    logic [ttlc_pkg::TIME_BITS-1:0]  in_nu;
    logic                            wr_en;
    logic [IW-1:0]                   wr_idx;
    logic                            slot_expired;

    assign in_nu = s_axis_tdata[351:312];
    assign e_sum = {1'b0, s_axis_tdata[295:256]} + {9'd0, ttl_reg};
    assign slot_expired = (rd_exp_reg != '0) && (rd_exp_reg <= {1'b0, now_reg});

    // select compare mode per scan
    always_comb begin
        ctl = '0;
        ctl.check_valid   = (state_reg != S_FREE);
        ctl.check_key     = (state_reg == S_KEY);
        ctl.check_expired = (state_reg == S_EXP);
        ctl.check_oldest  = (state_reg == S_OLD);
    end

    ttlc_cmp u_cmp (
        .ctl(ctl), .slot_vld(rd_vld_reg), .slot_key(rd_key_reg),
        .slot_exp(rd_exp_reg), .slot_stamp(rd_stamp_reg), .req_key(key_reg),
        .now(now_reg), .best_vld(best_vld_reg), .best_exp(best_exp_reg),
        .best_stamp(best_stamp_reg), .take(take)
    );

    assign wr_en  = (state_reg == S_WRITE);
    assign wr_idx = best_idx_reg;

    // memory port: one read per cycle, one write
    always_ff @(posedge aclk) begin
        rd_key_reg   <= mem_key[addr_reg[IW-1:0]];
        rd_hdl_reg   <= mem_hdl[addr_reg[IW-1:0]];
        rd_exp_reg   <= mem_exp[addr_reg[IW-1:0]];
        rd_stamp_reg <= mem_stamp[addr_reg[IW-1:0]];
        rd_vld_reg   <= valid_reg[addr_reg[IW-1:0]];
        rd_idx_reg   <= addr_reg[IW-1:0];
        if (wr_en && !repl_reg) begin
            mem_key[wr_idx]   <= key_reg;
            mem_stamp[wr_idx] <= ctr_reg;
        end
        if (wr_en) begin
            mem_hdl[wr_idx] <= hdl_reg;
            mem_exp[wr_idx] <= sexp_reg;
        end
    end

    // sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            valid_reg <= '0;
            count_reg <= '0;
            ctr_reg   <= '0;
            ttl_reg   <= ttlc_pkg::TTL_RESET;
            addr_reg  <= '0;
            rd_live_reg <= 1'b0;
        end else begin
            if (cfg_we) ttl_reg <= cfg_wdata;
            unique case (state_reg)
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        cmd_reg  <= s_axis_tuser;
                        key_reg  <= s_axis_tdata[255:0];
                        now_reg  <= s_axis_tdata[295:256];
                        hdl_reg  <= HANDLE_BITS'(s_axis_tdata[311:296]);
                        sexp_reg <= (in_nu != '0 && {1'b0, in_nu} < e_sum) ?
                                    {1'b0, in_nu} : e_sum;
                        hit_reg <= 1'b0; repl_reg <= 1'b0; evic_reg <= 1'b0;
                        found_reg <= '0; freed_reg <= '0;
                        best_vld_reg <= 1'b0;
                        addr_reg <= '0;
                        rd_live_reg <= 1'b0;
                        state_reg <= S_KEY;
                    end
                end
                S_KEY, S_EXP, S_OLD, S_FREE: begin
                    // advance read address; evaluate previous read
                    if (addr_reg <= LAST) addr_reg <= addr_reg + 1'b1;
                    rd_live_reg <= (addr_reg <= LAST);
                    if (rd_live_reg && take && !(state_reg == S_KEY && best_vld_reg)
                        && !(state_reg == S_FREE && best_vld_reg)) begin
                        best_vld_reg   <= 1'b1;
                        best_idx_reg   <= rd_idx_reg;
                        best_exp_reg   <= rd_exp_reg;
                        best_stamp_reg <= rd_stamp_reg;
                        best_hdl_reg   <= rd_hdl_reg;
                    end
                    if (rd_live_reg && rd_idx_reg == LAST[IW-1:0]) begin
                        addr_reg    <= '0;
                        rd_live_reg <= 1'b0;
                        best_vld_reg <= 1'b0;
                        priority case (state_reg)
                            S_KEY: begin
                                if (take && !best_vld_reg) begin
                                    best_idx_reg <= rd_idx_reg;
                                    best_hdl_reg <= rd_hdl_reg;
                                end
                                if (cmd_reg == ttlc_pkg::CMD_LOOKUP) begin
                                    if (take && !best_vld_reg) begin
                                        hit_reg <= !slot_expired;
                                        found_reg <= slot_expired ? '0 :
                                            ttlc_pkg::HANDLE_W'(rd_hdl_reg);
                                    end else if (best_vld_reg) begin
                                        hit_reg <= !((best_exp_reg != '0) &&
                                            (best_exp_reg <= {1'b0, now_reg}));
                                        found_reg <= ((best_exp_reg != '0) &&
                                            (best_exp_reg <= {1'b0, now_reg})) ?
                                            '0 : ttlc_pkg::HANDLE_W'(best_hdl_reg);
                                    end
                                    sexp_reg  <= '0;
                                    state_reg <= S_OUT;
                                end else if (best_vld_reg || take) begin
                                    repl_reg  <= 1'b1;
                                    freed_reg <= ttlc_pkg::HANDLE_W'(best_vld_reg ?
                                                 best_hdl_reg : rd_hdl_reg);
                                    state_reg <= S_WRITE;
                                end else begin
                                    state_reg <= (count_reg >= FULL) ? S_EXP : S_FREE;
                                end
                            end
                            S_EXP: begin
                                if (best_vld_reg || take) begin
                                    evic_reg  <= 1'b1;
                                    freed_reg <= ttlc_pkg::HANDLE_W'(take ?
                                                 rd_hdl_reg : best_hdl_reg);
                                    valid_reg[take ? rd_idx_reg : best_idx_reg] <= 1'b0;
                                    count_reg <= count_reg - 1'b1;
                                    state_reg <= S_FREE;
                                end else begin
                                    state_reg <= S_OLD;
                                end
                            end
                            S_OLD: begin
                                evic_reg  <= 1'b1;
                                freed_reg <= ttlc_pkg::HANDLE_W'(take ?
                                             rd_hdl_reg : best_hdl_reg);
                                valid_reg[take ? rd_idx_reg : best_idx_reg] <= 1'b0;
                                count_reg <= count_reg - 1'b1;
                                state_reg <= S_FREE;
                            end
                            default: begin
                                if (take && !best_vld_reg) best_idx_reg <= rd_idx_reg;
                                state_reg <= S_WRITE;
                            end
                        endcase
                    end
                end
                S_WRITE: begin
                    if (!repl_reg) begin
                        valid_reg[best_idx_reg] <= 1'b1;
                        count_reg <= count_reg + 1'b1;
                        ctr_reg   <= ctr_reg + 1'b1;
                    end
                    state_reg <= S_OUT;
                end
                S_OUT: begin
                    if (m_axis_tready) state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = (state_reg == S_OUT);
    assign m_axis_tdata  = {4'd0, sexp_reg, freed_reg, evic_reg, repl_reg,
                            found_reg, hit_reg};

    // checks
    a_one_side: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_axis_tready && m_axis_tvalid)) else $error("ready during output");
    a_count: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= FULL) else $error("entry count overflow");
    a_hit_lookup: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && hit_reg |-> !repl_reg && !evic_reg) else $error("hit on store");
endmodule
`default_nettype wire

// ----- sim/tb.sv -----
`timescale 1ns / 1ps
module tb;
    localparam int SLOTS = 128;
    localparam longint CYCLE_LIMIT = 4000000;

    typedef struct packed {
        logic        cmd;
        logic [63:0] k0, k1, k2, k3;
        logic [39:0] now_s;
        logic [15:0] handle;
        logic [39:0] next_upd;
    } req_t;

    // hit sits in the lowest bit, stored expiry in the highest
    typedef struct packed {
        logic [40:0] sexp;
        logic [15:0] freed;
        logic        evicted;
        logic        replaced;
        logic [15:0] found;
        logic        hit;
    } resp_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_we = 1'b0;
    logic [31:0] cfg_wdata = '0;
    logic s_axis_tvalid = 1'b0;
    wire  s_axis_tready;
    logic s_axis_tuser = 1'b0;
    logic [351:0] s_axis_tdata = '0;
    wire  m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    wire  [79:0] m_axis_tdata;

    ttl_keyed_cache_with_expiry_eviction DUT (
        .aclk(aclk), .aresetn(aresetn), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tuser(s_axis_tuser), .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    // cache mirror
    logic [31:0]  ttl_reg;
    logic         c_valid [SLOTS];
    logic [255:0] c_key [SLOTS];
    logic [15:0]  c_handle [SLOTS];
    logic [40:0]  c_exp [SLOTS];
    logic [63:0]  c_stamp [SLOTS];
    logic [63:0]  ins_count;
    int           c_count;

    req_t  pending_reqs[$];
    resp_t expected_resps[$];
    int    error_count = 0;
    bit    hold_send = 0;
    bit    no_idle = 0;
    longint cycle_count = 0;

    // key pool keeps collisions and replaces frequent
    logic [255:0] key_pool [64];

    function automatic bit slot_expired(int i, logic [39:0] now_s);
        return c_exp[i] != 0 && c_exp[i] <= {1'b0, now_s};
    endfunction

    function automatic resp_t cache_predict(req_t r);
        resp_t o;
        logic [255:0] k;
        logic [40:0] e;
        int idx, best;
        o = '0;
        k = {r.k3, r.k2, r.k1, r.k0};
        idx = -1;
        for (int i = 0; i < SLOTS; i++)
            if (idx < 0 && c_valid[i] && c_key[i] == k) idx = i;
        if (r.cmd == ttlc_pkg::CMD_LOOKUP) begin
            if (idx >= 0 && !slot_expired(idx, r.now_s)) begin
                o.hit = 1'b1;
                o.found = c_handle[idx];
            end
        end else begin
            e = {1'b0, r.now_s} + {9'd0, ttl_reg};
            if (r.next_upd != 0 && {1'b0, r.next_upd} < e) e = {1'b0, r.next_upd};
            o.sexp = e;
            if (idx >= 0) begin
                o.replaced = 1'b1;
                o.freed = c_handle[idx];
                c_handle[idx] = r.handle;
                c_exp[idx] = e;
            end else begin
                if (c_count >= SLOTS) begin
                    best = -1;
                    for (int i = 0; i < SLOTS; i++)
                        if (c_valid[i] && slot_expired(i, r.now_s) &&
                            (best < 0 || c_stamp[i] > c_stamp[best])) best = i;
                    if (best < 0)
                        for (int i = 0; i < SLOTS; i++)
                            if (c_valid[i] && (best < 0 || c_exp[i] < c_exp[best] ||
                                (c_exp[i] == c_exp[best] && c_stamp[i] > c_stamp[best])))
                                best = i;
                    o.evicted = 1'b1;
                    o.freed = c_handle[best];
                    c_valid[best] = 1'b0;
                    c_count--;
                end
                for (int i = 0; i < SLOTS; i++)
                    if (!c_valid[i]) begin
                        c_valid[i] = 1'b1;
                        c_key[i] = k;
                        c_handle[i] = r.handle;
                        c_exp[i] = e;
                        c_stamp[i] = ins_count;
                        ins_count++;
                        c_count++;
                        break;
                    end
            end
        end
        return o;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("MISMATCH %s: got %h expected %h", what, got, want);
        error_count++;
    endtask

    function automatic req_t make_req(bit cmd, logic [255:0] k, logic [39:0] now_s,
                                      logic [15:0] h, logic [39:0] nu);
        req_t r;
        r.cmd = cmd;
        {r.k3, r.k2, r.k1, r.k0} = k;
        r.now_s = now_s;
        r.handle = h;
        r.next_upd = nu;
        return r;
    endfunction

    // tdata layout: key words from the lowest bits up, then time, handle, next update
    function automatic logic [351:0] pack_req(req_t r);
        return {r.next_upd, r.handle, r.now_s, r.k3, r.k2, r.k1, r.k0};
    endfunction

    function automatic logic [255:0] rand_key();
        return {$urandom, $urandom, $urandom, $urandom,
                $urandom, $urandom, $urandom, $urandom};
    endfunction

    function automatic logic [39:0] rand40();
        return {8'($urandom_range(255, 0)), $urandom};
    endfunction

    // driver: present the queue head, pop on transaction
    int send_gap = 0;
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_axis_tvalid <= 1'b0;
        end else if (s_axis_tvalid && s_axis_tready) begin
            if (!no_idle && $urandom_range(3, 0) == 0) send_gap = $urandom_range(19, 1);
            if (pending_reqs.size() > 0 && send_gap == 0 && !hold_send) begin
                s_axis_tdata <= pack_req(pending_reqs[0]);
                s_axis_tuser <= pending_reqs[0].cmd;
                expected_resps.push_back(cache_predict(pending_reqs.pop_front()));
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end else if (!s_axis_tvalid) begin
            if (send_gap > 0) send_gap--;
            else if (pending_reqs.size() > 0 && !hold_send) begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata <= pack_req(pending_reqs[0]);
                s_axis_tuser <= pending_reqs[0].cmd;
                expected_resps.push_back(cache_predict(pending_reqs.pop_front()));
            end
        end
    end

    // monitor: compare each result transaction with the oldest expectation
    int recv_gap = 0;
    always @(posedge aclk) begin
        resp_t got, want;
        if (!aresetn) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got = m_axis_tdata[75:0];
                if (expected_resps.size() == 0) begin
                    report_mismatch("unexpected result", 64'(got), 64'd0);
                end else begin
                    want = expected_resps.pop_front();
                    if (got.hit != want.hit)
                        report_mismatch("hit", 64'(got.hit), 64'(want.hit));
                    if (got.found != want.found)
                        report_mismatch("found_handle", 64'(got.found), 64'(want.found));
                    if (got.replaced != want.replaced)
                        report_mismatch("replaced", 64'(got.replaced),
                                        64'(want.replaced));
                    if (got.evicted != want.evicted)
                        report_mismatch("evicted", 64'(got.evicted), 64'(want.evicted));
                    if (got.freed != want.freed)
                        report_mismatch("freed_handle", 64'(got.freed), 64'(want.freed));
                    if (got.sexp != want.sexp)
                        report_mismatch("stored_expiry", 64'(got.sexp), 64'(want.sexp));
                end
            end
            if (recv_gap > 0) begin
                recv_gap--;
                m_axis_tready <= 1'b0;
            end else if (!no_idle && $urandom_range(15, 0) == 0) begin
                recv_gap = $urandom_range(19, 1);
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic drain();
        while (pending_reqs.size() > 0 || s_axis_tvalid || expected_resps.size() > 0)
            @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic write_ttl(logic [31:0] v);
        @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        ttl_reg = v;
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic random_phase(int n, logic [39:0] base);
        logic [39:0] t;
        logic [39:0] nu;
        int sel;
        t = base;
        for (int i = 0; i < n; i++) begin
            t = t + $urandom_range(400, 0);
            sel = $urandom_range(9, 0);
            nu = (sel < 4) ? 40'd0 : (sel < 8) ? t + $urandom_range(5000, 0) : rand40();
            pending_reqs.push_back(make_req(1'($urandom_range(1, 0)),
                ($urandom_range(7, 0) == 0) ? rand_key() : key_pool[$urandom_range(63, 0)],
                ($urandom_range(19, 0) == 0) ? rand40() : t,
                16'($urandom_range(65535, 0)), nu));
        end
    endtask

    initial begin
        logic [255:0] ka, kb;
        ttl_reg = ttlc_pkg::TTL_RESET;
        for (int i = 0; i < SLOTS; i++) c_valid[i] = 1'b0;
        ins_count = 0;
        c_count = 0;
        for (int i = 0; i < 64; i++) key_pool[i] = rand_key();
        // pool pattern keys for extremes
        key_pool[0] = '0;
        key_pool[1] = '1;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: misses, stores, hits, expired hits, replace, clamps
        ka = key_pool[0];
        kb = key_pool[1];
        pending_reqs.push_back(make_req(ttlc_pkg::CMD_LOOKUP, ka, 40'd0, 16'hFFFF, 40'd0));
        pending_reqs.push_back(make_req(ttlc_pkg::CMD_STORE, ka, 40'd100, 16'hFFFF, 40'd0));
        pending_reqs.push_back(make_req(ttlc_pkg::CMD_LOOKUP, ka, 40'd200, 16'd0, 40'd0));
        pending_reqs.push_back(make_req(ttlc_pkg::CMD_LOOKUP, ka, 40'd3700, 16'd0, 40'd0));
        pending_reqs.push_back(make_req(ttlc_pkg::CMD_LOOKUP, ka, 40'd3699, 16'd0, 40'd0));
        pending_reqs.push_back(make_req(ttlc_pkg::CMD_STORE, ka, 40'd5000, 16'h1234,
                                        40'd5010));
        pending_reqs.push_back(make_req(ttlc_pkg::CMD_STORE, kb, 40'hFF_FFFF_FFFF, 16'h0,
                                        40'hFF_FFFF_FFFF));
        pending_reqs.push_back(make_req(ttlc_pkg::CMD_LOOKUP, kb, 40'hFF_FFFF_FFFF, 16'h0,
                                        40'd0));
        pending_reqs.push_back(make_req(ttlc_pkg::CMD_STORE, kb, 40'd10, 16'hA5A5,
                                        40'd20000));
        pending_reqs.push_back(make_req(ttlc_pkg::CMD_LOOKUP, ka, 40'd6000, 16'd0, 40'd0));
        pending_reqs.push_back(make_req(ttlc_pkg::CMD_STORE, ka, 40'd6000, 16'h5A5A,
                                        40'd1));
        pending_reqs.push_back(make_req(ttlc_pkg::CMD_LOOKUP, ka, 40'd6000, 16'd0, 40'd0));
        drain();

        // never-expiring entries: ttl 0, now 0
        write_ttl(32'd0);
        pending_reqs.push_back(make_req(ttlc_pkg::CMD_STORE, key_pool[2], 40'd0, 16'h0777,
                                        40'd0));
        pending_reqs.push_back(make_req(ttlc_pkg::CMD_LOOKUP, key_pool[2], 40'hFF_FFFF_FFFF,
                                        16'd0, 40'd0));
        drain();

        // fill past capacity so eviction runs, one pause for all results
        write_ttl(32'hFFFF_FFFF);
        for (int i = 0; i < 140; i++)
            pending_reqs.push_back(make_req(ttlc_pkg::CMD_STORE, rand_key(), 40'd1000 + i,
                                            16'($urandom_range(65535, 0)),
                                            (i % 3 == 0) ? 40'd1000 + 3 * i : 40'd0));
        // hold the sender midway until every outstanding result is back
        while (pending_reqs.size() > 70) @(posedge aclk);
        hold_send = 1;
        while (s_axis_tvalid || expected_resps.size() > 0) @(posedge aclk);
        hold_send = 0;
        drain();

        // random phases over several ttl settings
        write_ttl(32'd60);
        random_phase(400, 40'd2000);
        drain();
        write_ttl($urandom);
        random_phase(400, 40'd500000);
        drain();
        write_ttl(32'd1);
        random_phase(400, 40'hF0_0000_0000);
        drain();
        no_idle = 1;
        write_ttl(ttlc_pkg::TTL_RESET);
        random_phase(350, 40'd900000);
        drain();

        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end
endmodule
